FILE: hw/rtl/vsht_pkg.sv
// Shared types, constants and register codes of the voice segment hangover tracker.
`timescale 1ns / 1ps
`default_nettype none

package vsht_pkg;

  localparam int RING_SLOTS = 512;
  localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  localparam int PROB_W     = 9;
  localparam int STEP_W     = 4;
  localparam int COUNT_W    = 8;
  localparam int LEN_W      = 10;
  localparam int OUT_SLOT_W = 9;
  localparam int REASON_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [LEN_W-1:0]  LEN_MAX   = {LEN_W{1'b1}};
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_SLOTS - 1);

  localparam logic [REASON_W-1:0] REASON_NONE      = 2'd0;
  localparam logic [REASON_W-1:0] REASON_EXPIRED   = 2'd1;
  localparam logic [REASON_W-1:0] REASON_RING_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_LOW        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_HIGH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_STEP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HANGOVER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH     = 3'd6;

  typedef struct packed {
    logic [PROB_W-1:0]  low_threshold;
    logic [PROB_W-1:0]  high_threshold;
    logic [STEP_W-1:0]  inc_low;
    logic [STEP_W-1:0]  inc_high;
    logic [STEP_W-1:0]  dec_step;
    logic [COUNT_W-1:0] max_hangover;
    logic [LEN_W-1:0]   min_length;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] hangover_count;
    logic [LEN_W-1:0]   segment_length;
    logic [SLOT_W-1:0]  start_slot;
    logic [SLOT_W-1:0]  next_slot;
  } state_t;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] write_slot;
    logic                  publish;
    logic [REASON_W-1:0]   end_reason;
    logic [OUT_SLOT_W-1:0] seg_start;
    logic [OUT_SLOT_W-1:0] seg_end;
    logic [COUNT_W-1:0]    hangover_left;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vsht_step.sv
// Per-chunk decision logic: next tracker state and the result for one request.
`timescale 1ns / 1ps
`default_nettype none

module vsht_step (
  input  vsht_pkg::cfg_t               cfg,
  input  vsht_pkg::state_t             state,
  input  logic [vsht_pkg::PROB_W-1:0]  chunk_prob,
  output vsht_pkg::state_t             state_next,
  output vsht_pkg::result_t            result
);
  import vsht_pkg::*;

  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  slot_after;
  logic [SLOT_W-1:0]  start_new;
  logic [LEN_W-1:0]   len_new;
  logic [COUNT_W-1:0] count_new;
  logic [STEP_W-1:0]  step;
  logic [COUNT_W:0]   sum;
  logic               voice;
  logic               pub;
  logic [REASON_W-1:0] reason;
  logic [SLOT_W-1:0]  pub_start;
  logic [SLOT_W-1:0]  pub_end;

  always_comb begin
    slot       = state.next_slot;
    slot_after = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
    start_new  = state.start_slot;
    len_new    = (state.segment_length != LEN_MAX) ?
                 state.segment_length + 1'b1 : state.segment_length;
    voice      = chunk_prob >= cfg.low_threshold;
    step       = (chunk_prob >= cfg.high_threshold) ? cfg.inc_high : cfg.inc_low;
    sum        = {1'b0, state.hangover_count} + {{(COUNT_W+1-STEP_W){1'b0}}, step};
    pub        = 1'b0;
    reason     = REASON_NONE;
    pub_start  = '0;
    pub_end    = '0;
    count_new  = state.hangover_count;

    if (voice) begin
      if (state.hangover_count == '0) begin
        start_new = slot;
        len_new   = LEN_W'(1);
      end
      count_new = (sum < {1'b0, cfg.max_hangover}) ? sum[COUNT_W-1:0] : cfg.max_hangover;
    end else begin
      count_new = (state.hangover_count > COUNT_W'(cfg.dec_step)) ?
                  state.hangover_count - COUNT_W'(cfg.dec_step) : '0;
      if (count_new == '0) begin
        if (len_new >= cfg.min_length) begin
          pub       = 1'b1;
          reason    = REASON_EXPIRED;
          pub_start = state.start_slot;
          pub_end   = slot_after;
        end
        len_new = '0;
      end
    end

    // The ring wrapped onto the open segment's first slot.
    if (len_new != '0 && start_new == slot_after) begin
      pub       = 1'b1;
      reason    = REASON_RING_FULL;
      pub_start = start_new;
      pub_end   = slot_after;
      len_new   = '0;
      count_new = '0;
    end

    state_next.hangover_count = count_new;
    state_next.segment_length = len_new;
    state_next.start_slot     = start_new;
    state_next.next_slot      = slot_after;

    result.write_slot    = OUT_SLOT_W'(slot);
    result.publish       = pub;
    result.end_reason    = reason;
    result.seg_start     = OUT_SLOT_W'(pub_start);
    result.seg_end       = OUT_SLOT_W'(pub_end);
    result.hangover_left = count_new;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/voice_segment_hangover_tracker.sv
// Top level of the voice segment hangover tracker: registers, handshake and result register.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------------
//   input    | in        | in_valid/in_stall  | chunk_prob
//   output   | out       | out_valid/out_stall| write_slot publish end_reason seg_start
//            |           |                    | seg_end hangover_left
//   config   | in        | cfg_we             | cfg_index cfg_data
//
// One request per cycle while in_stall is low; its result appears in the result register in the cycle after acceptance.
// The tracker state and the result register update in the same edge from one pass of logic.
// in_stall rises only while a result is held and out_stall is high.
// Reset restores the register defaults, clears the tracker state and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module voice_segment_hangover_tracker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [vsht_pkg::PROB_W-1:0]     chunk_prob,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [vsht_pkg::OUT_SLOT_W-1:0] write_slot,
  output logic                            publish,
  output logic [vsht_pkg::REASON_W-1:0]   end_reason,
  output logic [vsht_pkg::OUT_SLOT_W-1:0] seg_start,
  output logic [vsht_pkg::OUT_SLOT_W-1:0] seg_end,
  output logic [vsht_pkg::COUNT_W-1:0]    hangover_left,
  input  logic                            cfg_we,
  input  logic [vsht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vsht_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vsht_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t result_next;
  result_t result;
  logic    accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  vsht_step u_step (
    .cfg        (cfg),
    .state      (state),
    .chunk_prob (chunk_prob),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold  <= PROB_W'(141);
      cfg.high_threshold <= PROB_W'(205);
      cfg.inc_low        <= STEP_W'(1);
      cfg.inc_high       <= STEP_W'(2);
      cfg.dec_step       <= STEP_W'(1);
      cfg.max_hangover   <= COUNT_W'(70);
      cfg.min_length     <= LEN_W'(60);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_THRESHOLD:  cfg.low_threshold  <= cfg_data[PROB_W-1:0];
        CFG_HIGH_THRESHOLD: cfg.high_threshold <= cfg_data[PROB_W-1:0];
        CFG_INC_LOW:        cfg.inc_low        <= cfg_data[STEP_W-1:0];
        CFG_INC_HIGH:       cfg.inc_high       <= cfg_data[STEP_W-1:0];
        CFG_DEC_STEP:       cfg.dec_step       <= cfg_data[STEP_W-1:0];
        CFG_MAX_HANGOVER:   cfg.max_hangover   <= cfg_data[COUNT_W-1:0];
        CFG_MIN_LENGTH:     cfg.min_length     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign write_slot    = result.write_slot;
  assign publish       = result.publish;
  assign end_reason    = result.end_reason;
  assign seg_start     = result.seg_start;
  assign seg_end       = result.seg_end;
  assign hangover_left = result.hangover_left;

endmodule

`default_nettype wire

FILE: hw/rtl/vsht_checker.sv
// Port-level checker for the voice segment hangover tracker and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module vsht_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [vsht_pkg::OUT_SLOT_W-1:0] write_slot,
  input wire logic                            publish,
  input wire logic [vsht_pkg::REASON_W-1:0]   end_reason,
  input wire logic [vsht_pkg::OUT_SLOT_W-1:0] seg_start,
  input wire logic [vsht_pkg::OUT_SLOT_W-1:0] seg_end
);
  import vsht_pkg::*;

  // The output is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // The input is held back only by a stalled, pending result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a pending stalled result");

  // A published segment always carries a reason, and a quiet result carries none.
  a_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (publish == (end_reason != REASON_NONE)))
    else $error("publish and end reason disagree");

  // A result without a publish reports empty segment bounds.
  a_quiet_bounds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !publish) |-> (seg_start == '0 && seg_end == '0))
    else $error("segment bounds set without publish");

  // A stalled result holds its slot.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(write_slot)))
    else $error("stalled result changed");

endmodule

bind voice_segment_hangover_tracker vsht_checker u_vsht_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .write_slot (write_slot),
  .publish    (publish),
  .end_reason (end_reason),
  .seg_start  (seg_start),
  .seg_end    (seg_end)
);

`default_nettype wire

FILE: tb/sv/voice_segment_hangover_tracker_tb.sv
// Self-checking testbench for the voice segment hangover tracker: directed table, random phases.
`timescale 1ns / 1ps

module voice_segment_hangover_tracker_tb;
  import vsht_pkg::*;

  localparam int PHASES       = 10;
  localparam int PHASE_CHUNKS = 110;
  localparam int RING_RUN     = RING_SLOTS + 3;
  localparam int REG_COUNT    = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum logic {ROW_CHUNK, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  known;
    result_t               want;
  } opening_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PROB_W-1:0]     chunk_prob = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_SLOT_W-1:0] write_slot;
  logic                  publish;
  logic [REASON_W-1:0]   end_reason;
  logic [OUT_SLOT_W-1:0] seg_start;
  logic [OUT_SLOT_W-1:0] seg_end;
  logic [COUNT_W-1:0]    hangover_left;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t               regs_q;
  logic [COUNT_W-1:0] hang_q = '0;
  logic [LEN_W-1:0]   len_q = '0;
  logic [SLOT_W-1:0]  start_q = '0;
  logic [SLOT_W-1:0]  next_q = '0;

  result_t      chunk_results_due[$];
  opening_row_t opening_rows[$];
  int           mismatches = 0;
  bit           sender_quiet = 1'b0;
  int           stall_left = 0;
  bit           receiver_calm = 1'b0;

  voice_segment_hangover_tracker u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .chunk_prob(chunk_prob),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .write_slot(write_slot),
    .publish(publish),
    .end_reason(end_reason),
    .seg_start(seg_start),
    .seg_end(seg_end),
    .hangover_left(hangover_left),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic result_t track_chunk(input logic [PROB_W-1:0] p);
    result_t              r;
    logic [SLOT_W-1:0]    slot;
    logic [STEP_W-1:0]    step;
    logic [COUNT_W:0]     sum;
    r = '0;
    slot = next_q;
    next_q = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
    if (len_q != LEN_MAX) len_q = len_q + 1'b1;
    if (p >= regs_q.low_threshold) begin
      if (hang_q == '0) begin
        start_q = slot;
        len_q = LEN_W'(1);
      end
      step = (p >= regs_q.high_threshold) ? regs_q.inc_high : regs_q.inc_low;
      sum = {1'b0, hang_q} + {{(COUNT_W+1-STEP_W){1'b0}}, step};
      hang_q = (sum < {1'b0, regs_q.max_hangover}) ? sum[COUNT_W-1:0] : regs_q.max_hangover;
    end else begin
      hang_q = (hang_q > COUNT_W'(regs_q.dec_step)) ? hang_q - COUNT_W'(regs_q.dec_step) : '0;
      if (hang_q == '0) begin
        if (len_q >= regs_q.min_length) begin
          r.publish = 1'b1;
          r.end_reason = REASON_EXPIRED;
          r.seg_start = OUT_SLOT_W'(start_q);
          r.seg_end = OUT_SLOT_W'(next_q);
        end
        len_q = '0;
      end
    end
    // A segment that has wrapped all the way round the ring is cut off here.
    if (len_q != '0 && start_q == next_q) begin
      r.publish = 1'b1;
      r.end_reason = REASON_RING_FULL;
      r.seg_start = OUT_SLOT_W'(start_q);
      r.seg_end = OUT_SLOT_W'(next_q);
      len_q = '0;
      hang_q = '0;
    end
    r.write_slot = OUT_SLOT_W'(slot);
    r.hangover_left = hang_q;
    return r;
  endfunction

  function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    opening_rows.push_back('{ROW_REG, idx, val, 1'b0, result_t'('0)});
  endfunction

  function automatic void plan_chunk(input logic [PROB_W-1:0] p);
    opening_rows.push_back('{ROW_CHUNK, '0, CFG_DATA_W'(p), 1'b0, result_t'('0)});
  endfunction

  function automatic void plan_known(input logic [PROB_W-1:0] p, input int slot,
                                     input logic pub, input logic [REASON_W-1:0] reason,
                                     input int first, input int after, input int hang);
    result_t want;
    want.write_slot = OUT_SLOT_W'(slot);
    want.publish = pub;
    want.end_reason = reason;
    want.seg_start = OUT_SLOT_W'(first);
    want.seg_end = OUT_SLOT_W'(after);
    want.hangover_left = COUNT_W'(hang);
    opening_rows.push_back('{ROW_CHUNK, '0, CFG_DATA_W'(p), 1'b1, want});
  endfunction

  function automatic logic [PROB_W-1:0] voice_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return regs_q.low_threshold;
    if (r < 30 && regs_q.high_threshold >= regs_q.low_threshold) return regs_q.high_threshold;
    if (r < 60 && regs_q.high_threshold > regs_q.low_threshold)
      return PROB_W'($urandom_range(regs_q.low_threshold, regs_q.high_threshold - 1));
    if (regs_q.high_threshold > regs_q.low_threshold)
      return PROB_W'($urandom_range(regs_q.high_threshold, 511));
    return PROB_W'($urandom_range(regs_q.low_threshold, 511));
  endfunction

  function automatic logic [PROB_W-1:0] silence_level();
    if (regs_q.low_threshold == '0) return PROB_W'($urandom_range(0, 511));
    if ($urandom_range(0, 99) < 15) return regs_q.low_threshold - 1'b1;
    return PROB_W'($urandom_range(0, regs_q.low_threshold - 1));
  endfunction

  function automatic int sender_gap();
    int r;
    if (sender_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_chunk(input logic [PROB_W-1:0] p, input logic known, input result_t want);
    result_t due;
    int      gap;
    due = track_chunk(p);
    chunk_results_due.push_back(known ? want : due);
    in_valid <= 1'b1;
    chunk_prob <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      chunk_prob <= PROB_W'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (chunk_results_due.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_LOW_THRESHOLD:  regs_q.low_threshold = data[PROB_W-1:0];
      CFG_HIGH_THRESHOLD: regs_q.high_threshold = data[PROB_W-1:0];
      CFG_INC_LOW:        regs_q.inc_low = data[STEP_W-1:0];
      CFG_INC_HIGH:       regs_q.inc_high = data[STEP_W-1:0];
      CFG_DEC_STEP:       regs_q.dec_step = data[STEP_W-1:0];
      CFG_MAX_HANGOVER:   regs_q.max_hangover = data[COUNT_W-1:0];
      CFG_MIN_LENGTH:     regs_q.min_length = data[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    int pick;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) receiver_calm = !receiver_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (receiver_calm) begin
        out_stall <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          out_stall <= 1'b0;
        end else if (pick < 96) begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (chunk_results_due.size() == 0) begin
        note_mismatch($sformatf("result for slot %0d with no request pending", write_slot));
      end else begin
        want = chunk_results_due.pop_front();
        if (write_slot !== want.write_slot)
          note_mismatch($sformatf("write_slot %0d, want %0d", write_slot, want.write_slot));
        if (publish !== want.publish)
          note_mismatch($sformatf("slot %0d publish %0b, want %0b",
                                  want.write_slot, publish, want.publish));
        if (end_reason !== want.end_reason)
          note_mismatch($sformatf("slot %0d end_reason %0d, want %0d",
                                  want.write_slot, end_reason, want.end_reason));
        if (seg_start !== want.seg_start)
          note_mismatch($sformatf("slot %0d seg_start %0d, want %0d",
                                  want.write_slot, seg_start, want.seg_start));
        if (seg_end !== want.seg_end)
          note_mismatch($sformatf("slot %0d seg_end %0d, want %0d",
                                  want.write_slot, seg_end, want.seg_end));
        if (hangover_left !== want.hangover_left)
          note_mismatch($sformatf("slot %0d hangover_left %0d, want %0d",
                                  want.write_slot, hangover_left, want.hangover_left));
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] raw [REG_COUNT];
    opening_row_t          row;
    int                    sent;
    int                    run_len;
    int                    shape;

    regs_q.low_threshold = 9'd141;
    regs_q.high_threshold = 9'd205;
    regs_q.inc_low = 4'd1;
    regs_q.inc_high = 4'd2;
    regs_q.dec_step = 4'd1;
    regs_q.max_hangover = 8'd70;
    regs_q.min_length = 10'd60;

    // Thresholds at their reset values: edges of the low and high bands.
    plan_known(9'd0,   0, 1'b0, REASON_NONE, 0, 0, 0);
    plan_known(9'd140, 1, 1'b0, REASON_NONE, 0, 0, 0);
    plan_known(9'd141, 2, 1'b0, REASON_NONE, 0, 0, 1);
    plan_known(9'd204, 3, 1'b0, REASON_NONE, 0, 0, 2);
    plan_known(9'd205, 4, 1'b0, REASON_NONE, 0, 0, 4);
    plan_known(9'd511, 5, 1'b0, REASON_NONE, 0, 0, 6);
    // Oversized write data is cut to the register width.
    plan_reg(CFG_DEC_STEP, 10'h3FF);
    plan_reg(CFG_MIN_LENGTH, 10'd1);
    plan_known(9'd0, 6, 1'b1, REASON_EXPIRED, 2, 7, 0);
    // Silence with the counter at zero publishes from the stale start slot.
    plan_known(9'd0, 7, 1'b1, REASON_EXPIRED, 2, 8, 0);
    // Low threshold above the high one: the low compare decides.
    plan_reg(CFG_LOW_THRESHOLD, 10'd250);
    plan_reg(CFG_HIGH_THRESHOLD, 10'd100);
    plan_reg(CFG_INC_HIGH, 10'd0);
    plan_known(9'd200, 8, 1'b1, REASON_EXPIRED, 2, 9, 0);
    // A zero step leaves the counter at zero, so every voice chunk restarts the segment.
    plan_known(9'd255, 9, 1'b0, REASON_NONE, 0, 0, 0);
    plan_known(9'd255, 10, 1'b0, REASON_NONE, 0, 0, 0);
    plan_known(9'd0, 11, 1'b1, REASON_EXPIRED, 10, 12, 0);
    plan_reg(CFG_LOW_THRESHOLD, 10'd141);
    plan_reg(CFG_HIGH_THRESHOLD, 10'd205);
    plan_reg(CFG_INC_HIGH, 10'd15);
    plan_reg(CFG_DEC_STEP, 10'd1);
    plan_reg(CFG_MAX_HANGOVER, 10'd255);
    plan_reg(CFG_MIN_LENGTH, 10'd1000);
    plan_known(9'd511, 12, 1'b0, REASON_NONE, 0, 0, 15);
    plan_known(9'd511, 13, 1'b0, REASON_NONE, 0, 0, 30);
    // Lowering the ceiling under the counter clamps it on the next voice chunk.
    plan_reg(CFG_MAX_HANGOVER, 10'd3);
    plan_known(9'd511, 14, 1'b0, REASON_NONE, 0, 0, 3);
    plan_known(9'd0, 15, 1'b0, REASON_NONE, 0, 0, 2);
    plan_reg(CFG_SPARE, 10'h3FF);
    plan_chunk(9'd300);
    plan_chunk(9'd1);
    plan_chunk(9'd128);
    plan_chunk(9'd0);
    plan_chunk(9'd256);
    plan_chunk(9'd0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      if (row.kind == ROW_REG) begin
        drain_results();
        write_reg(row.idx, row.val);
      end else begin
        push_chunk(row.val[PROB_W-1:0], row.known, row.want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: foreach (raw[i]) raw[i] = '0;
        1: foreach (raw[i]) raw[i] = '1;
        2: begin
          raw[CFG_LOW_THRESHOLD] = 10'd141;
          raw[CFG_HIGH_THRESHOLD] = 10'd205;
          raw[CFG_INC_LOW] = 10'd1;
          raw[CFG_INC_HIGH] = 10'd2;
          raw[CFG_DEC_STEP] = 10'd1;
          raw[CFG_MAX_HANGOVER] = 10'd70;
          raw[CFG_MIN_LENGTH] = 10'd60;
        end
        default: begin
          raw[CFG_LOW_THRESHOLD] = CFG_DATA_W'($urandom_range(0, 300));
          raw[CFG_HIGH_THRESHOLD] = CFG_DATA_W'($urandom_range(0, 300));
          raw[CFG_INC_LOW] = CFG_DATA_W'($urandom_range(0, 15));
          raw[CFG_INC_HIGH] = CFG_DATA_W'($urandom_range(0, 15));
          raw[CFG_DEC_STEP] = CFG_DATA_W'($urandom_range(0, 15));
          raw[CFG_MAX_HANGOVER] = (phase == 3) ? CFG_DATA_W'($urandom_range(0, 4))
                                               : CFG_DATA_W'($urandom_range(0, 255));
          raw[CFG_MIN_LENGTH] = ($urandom_range(0, 9) < 7) ? CFG_DATA_W'($urandom_range(0, 40))
                                                           : CFG_DATA_W'($urandom_range(41, 300));
        end
      endcase
      foreach (raw[i]) write_reg(CFG_IDX_W'(i), raw[i]);
      if (phase > 2 && $urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      sender_quiet = ($urandom_range(0, 9) < 3);

      // Unbroken voice keeps the counter up until the segment wraps the ring.
      if (phase == 2)
        for (int j = 0; j < RING_RUN; j++) push_chunk(voice_level(), 1'b0, '0);

      sent = 0;
      while (sent < PHASE_CHUNKS) begin
        shape = $urandom_range(0, 99);
        if (shape < 45) begin
          run_len = $urandom_range(1, 60);
          for (int j = 0; j < run_len; j++) push_chunk(voice_level(), 1'b0, '0);
        end else if (shape < 85) begin
          run_len = $urandom_range(1, 40);
          for (int j = 0; j < run_len; j++) push_chunk(silence_level(), 1'b0, '0);
        end else begin
          run_len = $urandom_range(1, 10);
          for (int j = 0; j < run_len; j++)
            push_chunk(PROB_W'($urandom_range(0, 511)), 1'b0, '0);
        end
        sent += run_len;
        if ($urandom_range(0, 49) == 0) drain_results();
      end
      // End each phase mid-segment so the next settings meet a live counter where steps and ceiling let it rise.
      repeat (8) push_chunk(9'd511, 1'b0, '0);
    end

    drain_results();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("voice_segment_hangover_tracker_tb: done, clean");
    end else begin
      $display("voice_segment_hangover_tracker_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("voice_segment_hangover_tracker_tb: done, errors");
    $finish;
  end

endmodule
